// File: hdl/mnca_pkg.sv
// Shared types, constants and helper functions of the chunk allocator.
package mnca_pkg;

  localparam int MAX_NODES   = 8;
  localparam int NODE_CHUNKS = 1024;
  localparam int MAX_REQ     = 64;
  localparam int NODE_W      = 3;
  localparam int IDX_W       = 10;
  localparam int CNT_W       = 11;
  localparam int TALLY_W     = 7;
  localparam int NCH_W       = 14;
  localparam int RAM_AW      = NODE_W + IDX_W;
  localparam int RAM_DEPTH   = MAX_NODES * NODE_CHUNKS;
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  localparam logic       CMD_ALLOC  = 1'b0;
  localparam logic       CMD_FREE   = 1'b1;
  localparam logic [1:0] POL_PREF   = 2'd0;
  localparam logic [1:0] POL_LEAST  = 2'd1;
  localparam logic [1:0] POL_BAL    = 2'd2;
  localparam logic [1:0] POL_NONE   = 2'd3;

  localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [1:0] CFG_CHUNKS     = 2'd1;
  localparam logic [1:0] CFG_CHUNK_LOG  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NOMEM     = 3'd2,
    ST_TOOMANY   = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FREE, S_SUM, S_PICK, S_CHUNK, S_OUT
  } state_t;

  // Effective configuration as the datapath uses it.
  typedef struct packed {
    logic [3:0]       nodes;
    logic [CNT_W-1:0] cap;
    logic [4:0]       chunk_shift;
  } cfg_t;

  // One classified command as it travels from front to back.
  typedef struct packed {
    logic              is_free;
    logic              bad;
    logic [1:0]        policy;
    logic [NODE_W-1:0] first;
    logic [CNT_W-1:0]  th;
    logic [CNT_W-1:0]  clen;
    logic [NODE_W-1:0] fnode;
    logic [IDX_W-1:0]  fchunk;
    logic [NCH_W-1:0]  nch;
    logic              nch_big;
  } entry_t;

  function automatic logic [3:0] eff_nodes(input logic [3:0] raw);
    logic [3:0] r;
    if (raw == 4'd0) r = 4'd1;
    else if (raw > 4'(MAX_NODES)) r = 4'(MAX_NODES);
    else r = raw;
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] raw);
    return (raw > CNT_W'(NODE_CHUNKS)) ? CNT_W'(NODE_CHUNKS) : raw;
  endfunction

endpackage

// File: hdl/mnca_req_if.sv
// Request channel: allocate and free commands.
interface mnca_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [1:0]  policy;
  logic [47:0] request_bytes;
  logic [2:0]  first_node;
  logic [10:0] load_threshold;
  logic [10:0] cluster_length;
  logic [2:0]  free_node;
  logic [9:0]  free_chunk;

  modport source (output valid, cmd, policy, request_bytes, first_node, load_threshold,
                  cluster_length, free_node, free_chunk, input ready);
  modport sink (input valid, cmd, policy, request_bytes, first_node, load_threshold,
                cluster_length, free_node, free_chunk, output ready);
endinterface

// File: hdl/mnca_rsp_if.sv
// Response channel: one beat per allocated chunk or per status.
interface mnca_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] node;
  logic [9:0] chunk_id;
  logic       last;
  logic [2:0] most_used_node;

  modport source (output valid, status, node, chunk_id, last, most_used_node,
                  input ready);
  modport sink (input valid, status, node, chunk_id, last, most_used_node,
                output ready);
endinterface

// File: hdl/mnca_cfg_if.sv
// Configuration write channel.
interface mnca_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/mnca_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mnca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// File: hdl/mnca_front.sv
// Front end: accepts commands, sizes requests in chunks and checks arguments.
module mnca_front (
  mnca_req_if.sink         req,
  input  mnca_pkg::cfg_t   cfg,
  input  logic             full,
  output logic             push,
  output mnca_pkg::entry_t entry
);
  logic [48:0] round_mask;
  logic [48:0] sum;
  logic [48:0] shifted;
  logic        invalid;

  assign round_mask = (49'd1 << cfg.chunk_shift) - 49'd1;
  assign sum        = {1'b0, req.request_bytes} + round_mask;
  assign shifted    = sum >> cfg.chunk_shift;

  always_comb begin
    invalid = (req.policy == mnca_pkg::POL_NONE) || (req.request_bytes == 48'd0) ||
              ((req.policy == mnca_pkg::POL_PREF) && ({1'b0, req.first_node} >= cfg.nodes)) ||
              ((req.policy != mnca_pkg::POL_PREF) && (req.load_threshold > cfg.cap)) ||
              ((req.policy == mnca_pkg::POL_BAL) && (req.cluster_length == 11'd0));
    entry.is_free = (req.cmd == mnca_pkg::CMD_FREE);
    entry.bad     = entry.is_free ? ({1'b0, req.free_node} >= cfg.nodes) : invalid;
    entry.policy  = req.policy;
    entry.first   = req.first_node;
    entry.th      = req.load_threshold;
    entry.clen    = req.cluster_length;
    entry.fnode   = req.free_node;
    entry.fchunk  = req.free_chunk;
    entry.nch     = shifted[mnca_pkg::NCH_W-1:0];
    entry.nch_big = |shifted[48:mnca_pkg::NCH_W];
  end

  assign req.ready = !full;
  assign push      = req.valid && !full;
endmodule

// File: hdl/mnca_queue.sv
// Short queue of classified commands between front and back.
module mnca_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mnca_pkg::entry_t din,
  output logic             full,
  input  logic             pop,
  output mnca_pkg::entry_t dout,
  output logic             empty
);
  mnca_pkg::entry_t                 slots [mnca_pkg::QUEUE_DEPTH];
  logic [mnca_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [mnca_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [mnca_pkg::QUEUE_AW:0]      count;

  assign full  = (count == (mnca_pkg::QUEUE_AW+1)'(mnca_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
    if (push) slots[wr_ptr] <= din;
  end
endmodule

// File: hdl/mnca_back.sv
// Back end: keeps per-node usage, runs the policies and emits result beats.
module mnca_back (
  input  logic             clk,
  input  logic             rst,
  input  mnca_pkg::cfg_t   cfg,
  input  mnca_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  mnca_rsp_if.source       rsp
);
  localparam int N = mnca_pkg::MAX_NODES;
  localparam int CW = mnca_pkg::CNT_W;
  localparam int NW = mnca_pkg::NODE_W;

  mnca_pkg::state_t state, state_next;
  mnca_pkg::entry_t cur;
  mnca_pkg::status_t err_st, err_next;

  logic [CW-1:0]                used [N];
  logic [CW-1:0]                hw   [N];
  logic [mnca_pkg::TALLY_W-1:0] tally [N];
  logic [CW-1:0]                room [N];
  logic [N-1:0]                 avail;

  logic [NW-1:0]                node;
  logic [CW-1:0]                cluster;
  logic [mnca_pkg::TALLY_W-1:0] cnt;

  logic                     rs_single;
  mnca_pkg::status_t        rs_status;
  logic [NW-1:0]            rs_node;
  logic [mnca_pkg::IDX_W-1:0] rs_pos;
  logic                     rs_hit;
  logic                     rs_last;

  logic                     ov;
  logic [2:0]               o_status;
  logic [NW-1:0]            o_node;
  logic [mnca_pkg::IDX_W-1:0] o_idx;
  logic                     o_last;
  logic [NW-1:0]            o_most;

  logic [14:0]              total;
  logic                     anyfit;
  logic [CW-1:0]            want;
  logic [NW-1:0]            ll_node;
  logic [NW-1:0]            sel;
  logic [CW-1:0]            cluster_next;
  logic [NW-1:0]            most;
  logic                     out_load;
  logic                     ram_we;
  logic                     ram_re;
  logic [mnca_pkg::IDX_W-1:0] ram_rdata;
  logic [CW-1:0]            fused;

  // First node at or after n, in cyclic order, that still has a free chunk.
  function automatic logic [NW-1:0] skip_full(input logic [NW-1:0] n,
                                              input logic [3:0] nodes,
                                              input logic [N-1:0] av);
    logic [3:0]    c;
    logic [NW-1:0] r;
    logic          found;
    r = n;
    found = 1'b0;
    for (int i = 0; i < N; i++) begin
      c = {1'b0, n} + 4'(i);
      if (c >= nodes) c = c - nodes;
      if (!found && (4'(i) < nodes) && av[c[NW-1:0]]) begin
        r = c[NW-1:0];
        found = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < N; i++) begin
      room[i]  = (used[i] < cfg.cap) ? (cfg.cap - used[i]) : '0;
      avail[i] = (room[i] != '0);
    end
  end

  // Free space over all nodes in use, and whether one node fits the request.
  always_comb begin
    total  = '0;
    anyfit = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (4'(i) < cfg.nodes) begin
        total = total + 15'(room[i]);
        if ({3'b0, room[i]} >= cur.nch) anyfit = 1'b1;
      end
    end
  end

  always_comb begin
    if (cur.nch_big || ({1'b0, cur.nch} > total)) err_next = mnca_pkg::ST_NOMEM;
    else if ((cur.policy == mnca_pkg::POL_LEAST) && !anyfit) err_next = mnca_pkg::ST_NOMEM;
    else if (cur.nch > mnca_pkg::NCH_W'(mnca_pkg::MAX_REQ)) err_next = mnca_pkg::ST_TOOMANY;
    else err_next = mnca_pkg::ST_OK;
  end

  // Least-loaded pick: higher nodes win ties, node 0 needs the threshold margin.
  always_comb begin
    logic [CW-1:0] minu;
    want = (cur.policy == mnca_pkg::POL_LEAST) ? CW'(cur.nch[mnca_pkg::TALLY_W-1:0])
                                                : CW'(1);
    minu = cfg.cap;
    ll_node = '0;
    for (int i = 1; i < N; i++) begin
      if ((4'(i) < cfg.nodes) && (used[i] <= minu) && (room[i] >= want)) begin
        minu = used[i];
        ll_node = NW'(i);
      end
    end
    if (({1'b0, used[0]} + {1'b0, cur.th} < {1'b0, minu}) && (room[0] >= want))
      ll_node = '0;
  end

  always_comb begin
    logic [NW-1:0] base;
    logic [NW-1:0] nxt;
    base = node;
    nxt = node;
    sel = node;
    cluster_next = cluster;
    unique case (cur.policy)
      mnca_pkg::POL_PREF: sel = skip_full(node, cfg.nodes, avail);
      mnca_pkg::POL_BAL: begin
        if (cluster == cur.clen)
          base = ({1'b0, node} + 4'd1 == cfg.nodes) ? '0 : node + 1'b1;
        nxt = skip_full(base, cfg.nodes, avail);
        if (nxt != node) begin
          sel = nxt;
          cluster_next = CW'(1);
        end else begin
          cluster_next = cluster + 1'b1;
        end
      end
      default: sel = node;
    endcase
  end

  always_comb begin
    most = '0;
    for (int i = 1; i < N; i++)
      if ((4'(i) < cfg.nodes) && (tally[i] > tally[most])) most = NW'(i);
  end

  assign fused = used[cur.fnode];

  always_comb begin
    state_next = state;
    unique case (state)
      mnca_pkg::S_IDLE:
        if (!empty) begin
          if (head.bad) state_next = mnca_pkg::S_OUT;
          else if (head.is_free) state_next = mnca_pkg::S_FREE;
          else state_next = mnca_pkg::S_SUM;
        end
      mnca_pkg::S_FREE:  state_next = mnca_pkg::S_OUT;
      mnca_pkg::S_SUM:   state_next = mnca_pkg::S_PICK;
      mnca_pkg::S_PICK:
        state_next = (err_st != mnca_pkg::ST_OK) ? mnca_pkg::S_OUT : mnca_pkg::S_CHUNK;
      mnca_pkg::S_CHUNK: state_next = mnca_pkg::S_OUT;
      mnca_pkg::S_OUT:
        if (out_load) state_next = rs_last ? mnca_pkg::S_IDLE : mnca_pkg::S_CHUNK;
      default: state_next = mnca_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == mnca_pkg::S_IDLE) && !empty;
    ram_re   = (state == mnca_pkg::S_CHUNK);
    ram_we   = (state == mnca_pkg::S_FREE) && (fused != '0);
    out_load = (state == mnca_pkg::S_OUT) && (!ov || rsp.ready);
  end

  mnca_ram #(
    .WIDTH (mnca_pkg::IDX_W),
    .DEPTH (mnca_pkg::RAM_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({cur.fnode, fused[mnca_pkg::IDX_W-1:0] - 1'b1}),
    .wdata (cur.fchunk),
    .re    (ram_re),
    .raddr ({sel, used[sel][mnca_pkg::IDX_W-1:0]}),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mnca_pkg::S_IDLE;
      ov    <= 1'b0;
      for (int i = 0; i < N; i++) begin
        used[i]  <= '0;
        hw[i]    <= '0;
        tally[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) ov <= 1'b1;
      else if (rsp.ready) ov <= 1'b0;

      unique case (state)
        mnca_pkg::S_FREE:
          if (fused != '0) used[cur.fnode] <= fused - 1'b1;
        mnca_pkg::S_PICK:
          if (err_st == mnca_pkg::ST_OK)
            for (int i = 0; i < N; i++) tally[i] <= '0;
        mnca_pkg::S_CHUNK: begin
          used[sel]  <= used[sel] + 1'b1;
          // Slots below the high-water mark have been written by a free.
          if (used[sel] + 1'b1 > hw[sel]) hw[sel] <= used[sel] + 1'b1;
          tally[sel] <= tally[sel] + 1'b1;
        end
        default: ;
      endcase
    end

    unique case (state)
      mnca_pkg::S_IDLE:
        if (!empty) begin
          cur       <= head;
          rs_single <= 1'b1;
          rs_status <= mnca_pkg::ST_INVALID;
          rs_last   <= 1'b1;
        end
      mnca_pkg::S_FREE:
        rs_status <= (fused == '0) ? mnca_pkg::ST_UNDERFLOW : mnca_pkg::ST_OK;
      mnca_pkg::S_SUM: err_st <= err_next;
      mnca_pkg::S_PICK: begin
        rs_status <= err_st;
        node      <= (cur.policy == mnca_pkg::POL_PREF) ? cur.first : ll_node;
        cluster   <= '0;
        cnt       <= '0;
      end
      mnca_pkg::S_CHUNK: begin
        node      <= sel;
        cluster   <= cluster_next;
        cnt       <= cnt + 1'b1;
        rs_single <= 1'b0;
        rs_status <= mnca_pkg::ST_OK;
        rs_node   <= sel;
        rs_pos    <= used[sel][mnca_pkg::IDX_W-1:0];
        rs_hit    <= used[sel] < hw[sel];
        rs_last   <= (cnt + 1'b1) == cur.nch[mnca_pkg::TALLY_W-1:0];
      end
      default: ;
    endcase

    if (out_load) begin
      o_status <= rs_status;
      o_last   <= rs_last;
      o_node   <= rs_single ? '0 : rs_node;
      o_idx    <= rs_single ? '0 : (rs_hit ? ram_rdata : rs_pos);
      o_most   <= (rs_single || !rs_last) ? '0 : most;
    end
  end

  assign rsp.valid          = ov;
  assign rsp.status         = o_status;
  assign rsp.node           = o_node;
  assign rsp.chunk_id       = o_idx;
  assign rsp.last           = o_last;
  assign rsp.most_used_node = o_most;

  a_chunk_then_out: assert property (@(posedge clk) disable iff (rst)
    state == mnca_pkg::S_CHUNK |=> state == mnca_pkg::S_OUT)
    else $error("chunk step not followed by output step");
  a_sel_has_room: assert property (@(posedge clk) disable iff (rst)
    state == mnca_pkg::S_CHUNK |-> avail[sel])
    else $error("chunk taken from a full node");
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_load && rs_last |=> state == mnca_pkg::S_IDLE)
    else $error("request did not end after its last beat");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("stack read and written in one cycle");
endmodule

// File: hdl/multi_node_chunk_allocator_unit.sv
// Top level of the multi-node chunk allocator.
//
//   channel  dir  payload
//   cfg      in   index, data (node_count, chunks_per_node, chunk size shift)
//   req      in   cmd, policy, request_bytes, first_node, load_threshold,
//                 cluster_length, free_node, free_chunk
//   rsp      out  status, node, chunk_id, last, most_used_node
//
// States: a free runs FREE, OUT; a front reject OUT; a space-check reject SUM, PICK, OUT;
// an allocation SUM, PICK, then CHUNK and OUT per chunk, with one stack read per chunk.
// Reset is synchronous; the free stacks need no clearing pass, a per-node
// high-water mark stands in for their initial contents.
// A stalled rsp holds the back end only; the front keeps queueing up to two commands.
module multi_node_chunk_allocator_unit (
  input logic         clk,
  input logic         rst,
  mnca_cfg_if.sink    cfg,
  mnca_req_if.sink    req,
  mnca_rsp_if.source  rsp
);
  logic [3:0]                 node_count;
  logic [mnca_pkg::CNT_W-1:0] chunks_per_node;
  logic [4:0]                 chunk_shift;
  mnca_pkg::cfg_t             cfg_eff;
  mnca_pkg::entry_t           q_in;
  mnca_pkg::entry_t           q_out;
  logic                       q_push;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count      <= 4'd1;
      chunks_per_node <= mnca_pkg::CNT_W'(mnca_pkg::NODE_CHUNKS);
      chunk_shift     <= 5'd20;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mnca_pkg::CFG_NODE_COUNT: node_count      <= cfg.data[3:0];
        mnca_pkg::CFG_CHUNKS:     chunks_per_node <= cfg.data;
        mnca_pkg::CFG_CHUNK_LOG:  chunk_shift     <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  assign cfg_eff.nodes       = mnca_pkg::eff_nodes(node_count);
  assign cfg_eff.cap         = mnca_pkg::eff_cap(chunks_per_node);
  assign cfg_eff.chunk_shift = chunk_shift;

  mnca_front u_front (
    .req   (req),
    .cfg   (cfg_eff),
    .full  (q_full),
    .push  (q_push),
    .entry (q_in)
  );

  mnca_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_out),
    .empty (q_empty)
  );

  mnca_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_eff),
    .head  (q_out),
    .empty (q_empty),
    .pop   (q_pop),
    .rsp   (rsp)
  );
endmodule
